### hw/rtl/sab_pkg.sv
// Shared types and constants for the scanning ADC block averager.
// Used by sab_ctrl, sab_datapath, sab_checker and the top level; depends on nothing.
package sab_pkg;

  // Field widths.
  localparam int unsigned SampleW = 10;
  localparam int unsigned ValueW  = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned AvgW    = 8;

  // Divider: the quotient is taken one bit per step over the low half of the sum.
  localparam int unsigned DivW     = CountW + 1;
  localparam int unsigned DivSteps = AvgW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Channel scan.
  localparam int unsigned NumChannels = 3;
  localparam logic [ChanW-1:0] LastChannel = 2'd2;
  localparam logic [ChanW-1:0] FirstChannel = 2'd0;

  // Reset value of the samples-per-average register.
  localparam logic [CountW-1:0] SamplesReset = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic div_step;  // one restoring-division step
    logic commit;    // store the average and advance the channel
    logic publish;   // load the output register
  } sab_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the accepted sample completes a block
  } sab_sts_t;

endpackage

### hw/rtl/scanning_adc_block_averager.sv
// Top level of the scanning ADC block averager.
// Depends on sab_pkg, sab_ctrl and sab_datapath.
//
//   Channel   Signals                          Moves
//   --------  -------------------------------  ------------------------------
//   config    cfg_we_i, cfg_wdata_i            samples per average, no wait
//   input     in_valid_i/in_ready_o, sample_i  one 10-bit sample per transfer
//   output    out_valid_o/out_ready_i, fields  one result per input transfer
//
// A sample that does not end a block goes from its transfer to publish.
// A sample that ends a block first passes divide, where the 8-step restoring
// divider computes one quotient bit per cycle, then commit stores the average.
// One sample is in work at a time; the next input transfer is taken once the
// result sits in the output register, even while that result waits.
// Reset clears the accumulator, counter, channel and averages at once.
module scanning_adc_block_averager (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sab_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sab_pkg::SampleW-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sab_pkg::ChanW-1:0]   next_channel_o,
  output logic                        scan_done_o,
  output logic [sab_pkg::AvgW-1:0]    average_ch0_o,
  output logic [sab_pkg::AvgW-1:0]    average_ch1_o,
  output logic [sab_pkg::AvgW-1:0]    average_ch2_o
);
  import sab_pkg::*;

  sab_cmd_t cmd;
  sab_sts_t sts;

  // Sequencing of accept, divide, commit and publish.
  sab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Accumulator, divider and result storage.
  sab_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .next_channel_o (next_channel_o),
    .scan_done_o    (scan_done_o),
    .average_ch0_o  (average_ch0_o),
    .average_ch1_o  (average_ch1_o),
    .average_ch2_o  (average_ch2_o)
  );

endmodule

### hw/rtl/sab_ctrl.sv
// Controller state machine of the scanning ADC block averager.
// Depends on sab_pkg; drives the command struct for sab_datapath.
module sab_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sab_pkg::sab_sts_t sts_i,
  output sab_pkg::sab_cmd_t cmd_o
);
  import sab_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StCommit,
    StPublish
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             slot_free;

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !out_valid_q || out_ready_i;

  // Commands decoded from the state.
  assign in_ready_o       = (state_q == StIdle);
  assign cmd_o.accept     = in_valid_i && (state_q == StIdle);
  assign cmd_o.div_step   = (state_q == StDivide);
  assign cmd_o.commit     = (state_q == StCommit);
  assign cmd_o.publish    = (state_q == StPublish) && slot_free;
  assign out_valid_o      = out_valid_q;

  // The output register fills on publish and empties on a result transfer.
  assign out_valid_d = cmd_o.publish || (out_valid_q && !out_ready_i);

  // State, step counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            step_q  <= '0;
            state_q <= sts_i.hit ? StDivide : StPublish;
          end
        end
        StDivide: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= StCommit;
          end
        end
        StCommit: begin
          state_q <= StPublish;
        end
        StPublish: begin
          if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

### hw/rtl/sab_datapath.sv
// Datapath of the scanning ADC block averager: accumulator, divider,
// channel averages and output register. Depends on sab_pkg.
module sab_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sab_pkg::CountW-1:0] cfg_wdata_i,
  input  logic [sab_pkg::SampleW-1:0] sample_i,
  input  sab_pkg::sab_cmd_t          cmd_i,
  output sab_pkg::sab_sts_t          sts_o,
  output logic [sab_pkg::ChanW-1:0]  next_channel_o,
  output logic                       scan_done_o,
  output logic [sab_pkg::AvgW-1:0]   average_ch0_o,
  output logic [sab_pkg::AvgW-1:0]   average_ch1_o,
  output logic [sab_pkg::AvgW-1:0]   average_ch2_o
);
  import sab_pkg::*;

  logic [CountW-1:0] cfg_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic [ChanW-1:0]  chan_q;
  logic [AvgW-1:0]   avg_q [NumChannels];
  logic              done_q;

  logic [DivW-1:0]   rem_q;
  logic [AvgW-1:0]   quo_q;
  logic [DivW-1:0]   div_q;
  logic              sat_q;

  logic [ChanW-1:0]  ochan_q;
  logic              odone_q;
  logic [AvgW-1:0]   oavg_q [NumChannels];

  logic [ValueW-1:0] value;
  logic [SumW-1:0]   sum_nxt;
  logic [CountW-1:0] cnt_nxt;
  logic [DivW-1:0]   div_nxt;
  logic [DivW-1:0]   rem_init;
  logic [DivW:0]     trial;
  logic [DivW:0]     diff;
  logic              fits;
  logic [AvgW-1:0]   avg_val;

  // Accumulate the sample with its two low bits dropped.
  assign value   = sample_i[SampleW-1 -: ValueW];
  assign sum_nxt = sum_q + {{(SumW - ValueW){1'b0}}, value};
  assign cnt_nxt = count_q + CountW'(1);
  assign sts_o.hit = (cnt_nxt == cfg_q);

  // A count of zero means the counter wrapped: divide by 256.
  assign div_nxt  = (cnt_nxt == '0) ? DivW'(1 << CountW) : {1'b0, cnt_nxt};
  assign rem_init = {1'b0, sum_nxt[SumW-1 -: AvgW]};

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[AvgW-1]};
  assign fits  = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  // A high half at or above the divisor means the quotient exceeds 8 bits.
  assign avg_val = sat_q ? {AvgW{1'b1}} : quo_q;

  // Control state: register, accumulator, channel and stored averages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= SamplesReset;
      sum_q   <= '0;
      count_q <= '0;
      chan_q  <= FirstChannel;
      done_q  <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        avg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        done_q <= 1'b0;
        if (sts_o.hit) begin
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          sum_q   <= sum_nxt;
          count_q <= cnt_nxt;
        end
      end
      if (cmd_i.commit) begin
        for (int i = 0; i < NumChannels; i++) begin
          if (chan_q == ChanW'(i)) begin
            avg_q[i] <= avg_val;
          end
        end
        if (chan_q >= LastChannel) begin
          done_q <= (chan_q == LastChannel);
          chan_q <= FirstChannel;
        end else begin
          chan_q <= chan_q + ChanW'(1);
        end
      end
    end
  end

  // Divider and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.hit) begin
      rem_q <= rem_init;
      quo_q <= sum_nxt[AvgW-1:0];
      div_q <= div_nxt;
      sat_q <= (rem_init >= div_nxt);
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_q <= {quo_q[AvgW-2:0], fits};
    end
    if (cmd_i.publish) begin
      ochan_q <= chan_q;
      odone_q <= done_q;
      for (int i = 0; i < NumChannels; i++) begin
        oavg_q[i] <= avg_q[i];
      end
    end
  end

  assign next_channel_o = ochan_q;
  assign scan_done_o    = odone_q;
  assign average_ch0_o  = oavg_q[0];
  assign average_ch1_o  = oavg_q[1];
  assign average_ch2_o  = oavg_q[2];

endmodule

### hw/rtl/sab_checker.sv
// Port-level checks for the scanning ADC block averager.
// Depends on sab_pkg; bound to scanning_adc_block_averager below.
module sab_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [sab_pkg::CountW-1:0]  cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [sab_pkg::SampleW-1:0] sample_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sab_pkg::ChanW-1:0]   next_channel_o,
  input logic                        scan_done_o,
  input logic [sab_pkg::AvgW-1:0]    average_ch0_o,
  input logic [sab_pkg::AvgW-1:0]    average_ch1_o,
  input logic [sab_pkg::AvgW-1:0]    average_ch2_o
);
  import sab_pkg::*;

  // A pending result stays until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  // Only one sample is in work: ready drops after each input transfer.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is in work");

  // The scan never points at the unused channel code.
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> next_channel_o != 2'd3)
    else $error("next channel out of range");

  // A finished scan wraps the channel back to the first one.
  a_scan_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_done_o |-> next_channel_o == FirstChannel)
    else $error("scan done without channel wrap");

endmodule

bind scanning_adc_block_averager sab_checker u_sab_checker (.*);
